// ----- sv/bpp_pkg.sv -----
// ----------------------------------------------------------------------------
// bpp_pkg
// shared types and constants for the relativistic boris particle pusher
// ----------------------------------------------------------------------------
package bpp_pkg;

  // q12.20 fixed point
  parameter int FRAC_BITS = 20;

  // item kinds
  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_PUSH = 1'b1
  } kind_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_INV_CELL   = 2'd0,
    CFG_TIME_STEP  = 2'd1,
    CFG_GRID_CELLS = 2'd2
  } cfg_reg_e;

  // register reset values
  parameter logic [30:0] INV_CELL_RESET   = 31'd1048576;
  parameter logic [30:0] TIME_STEP_RESET  = 31'd0;
  parameter logic [10:0] GRID_CELLS_RESET = 11'd1024;

  // quotient bits of the two dividers
  parameter int QB_T = 31;
  parameter int QB_S = 22;

endpackage

// ----- sv/boris_particle_push.sv -----
// ----------------------------------------------------------------------------
// boris_particle_push
// relativistic boris momentum push on a periodic 1d grid, fully pipelined
// ----------------------------------------------------------------------------
// usage
//   input beats are taken when start is high and busy is low; busy stays low,
//   the pipeline never stalls, so one beat is taken every clock cycle
//   a load beat (kind 0) writes one cell of the field grid and gives no result
//   a push beat (kind 1) gives one result beat, result_valid high for one cycle
//   throughput: one item per cycle, set by the pipelined datapath; the grid
//   memories have one write and two read ports, loads write at the same
//   stage where pushes read, so every push sees exactly the loads before it
//   the divisions (t and s) and the square root for gamma are pipelined
//   restoring units, one result bit per stage
//   config writes on cfg_valid/cfg_ready, cfg_ready always high; they must
//   only be made while no item is in flight
//   reset clears the pipeline valids and the config registers; grid contents
//   are undefined until loaded
//   the receiver cannot stall: results are shown for exactly one cycle
// ----------------------------------------------------------------------------
module boris_particle_push
  import bpp_pkg::*;
#(
  parameter int GRID_DEPTH = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  // item channel
  input  logic               start,
  output logic               busy,
  input  logic               kind,
  input  logic [9:0]         grid_index,
  input  logic signed [31:0] cell_e_x,
  input  logic signed [31:0] cell_e_y,
  input  logic signed [31:0] cell_b_z,
  input  logic signed [31:0] position,
  input  logic signed [31:0] momentum_x,
  input  logic signed [31:0] momentum_y,
  input  logic signed [31:0] charge_to_mass,
  // result channel
  output logic               result_valid,
  output logic signed [31:0] new_momentum_x,
  output logic signed [31:0] new_momentum_y,
  output logic               out_of_box,
  // config write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  // working width, clamped
  localparam int W  = (VALUE_BITS < 16) ? 16 : ((VALUE_BITS > 32) ? 32 : VALUE_BITS);
  localparam int AW = $clog2(GRID_DEPTH);
  localparam int NW = $clog2(GRID_DEPTH + 1);
  localparam int IB = 24;   // bits of the integer cell index

  localparam logic signed [65:0] SAT_MAX = (66'sd1 <<< (W - 1)) - 66'sd1;
  localparam logic signed [65:0] SAT_MIN = -(66'sd1 <<< (W - 1));
  localparam logic signed [65:0] HALF66  = 66'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] HALF64  = 64'sd1 <<< (FRAC_BITS - 1);

  // stage map
  localparam int S_A    = 0;              // accepted beat, position product
  localparam int S_B    = S_A + 1;        // cell index split, far flag
  localparam int S_MOD0 = S_B + 1;        // modulo by grid size, one bit a stage
  localparam int S_C1   = S_MOD0 + IB;    // periodic wrap
  localparam int S_C2   = S_C1 + 1;       // read addresses, load write
  localparam int S_D    = S_C2 + 1;       // grid data returned
  localparam int S_E    = S_D + 1;        // interpolation products
  localparam int S_F    = S_E + 1;        // interpolated fields
  localparam int S_G    = S_F + 1;        // rqm * field
  localparam int S_H    = S_G + 1;        // rounded
  localparam int S_I    = S_H + 1;        // times dt
  localparam int S_J    = S_I + 1;        // kicks and rotation numerator
  localparam int S_K    = S_J + 1;        // first half kick
  localparam int S_L    = S_K + 1;        // squares
  localparam int S_RAD  = S_L + 1;        // radicand
  localparam int S_SQ0  = S_RAD + 1;      // square root, one bit a stage
  localparam int S_P    = S_SQ0 + 32;     // first divider set-up
  localparam int S_DV1  = S_P + 1;
  localparam int S_T    = S_DV1 + QB_T;   // t
  localparam int S_TT   = S_T + 1;        // t * t
  localparam int S_D2A  = S_TT + 1;       // second divider denominator
  localparam int S_D2B  = S_D2A + 1;      // second divider set-up
  localparam int S_DV2  = S_D2B + 1;
  localparam int S_S    = S_DV2 + QB_S;   // s
  localparam int S_R1   = S_S + 1;        // rotation, three shears
  localparam int S_R9   = S_R1 + 8;
  localparam int S_OUT  = S_R9 + 1;       // second half kick
  localparam int NST    = S_OUT + 1;

  typedef struct packed {
    logic                    push;
    logic                    wen;
    logic                    far;
    logic                    neg;
    logic [AW-1:0]           waddr;
    logic [AW-1:0]           lo_a;
    logic [AW-1:0]           hi_a;
    logic [AW-1:0]           lo_b;
    logic [AW-1:0]           hi_b;
    logic signed [31:0]      dx;
    logic signed [31:0]      dy;
    logic signed [31:0]      db;
    logic signed [31:0]      ux;
    logic signed [31:0]      uy;
    logic signed [31:0]      rqm;
    logic signed [31:0]      ex;
    logic signed [31:0]      ey;
    logic signed [31:0]      bz;
    logic signed [31:0]      kx;
    logic signed [31:0]      ky;
    logic signed [31:0]      num;
    logic signed [31:0]      t;
    logic signed [31:0]      s;
    logic signed [31:0]      rot;
    logic [19:0]             frac;
    logic [19:0]             frac_h;
    logic [IB-1:0]           absi;
    logic [NW-1:0]           rem;
    logic [NW-1:0]           lo;
    logic signed [63:0]      pr0;
    logic signed [63:0]      pr1;
    logic signed [63:0]      pr2;
    logic signed [63:0]      pr3;
    logic signed [63:0]      pr4;
    logic signed [63:0]      pr5;
    logic [63:0]             sv;
    logic [63:0]             sr;
    logic [52:0]             m;
    logic [42:0]             den;
    logic [43:0]             drem;
    logic [30:0]             quo;
  } item_t;

  function automatic logic signed [65:0] x66(input logic signed [31:0] v);
    return {{34{v[31]}}, v};
  endfunction

  function automatic logic signed [31:0] sat(input logic signed [65:0] v);
    if (v > SAT_MAX) begin
      return SAT_MAX[31:0];
    end else if (v < SAT_MIN) begin
      return SAT_MIN[31:0];
    end
    return v[31:0];
  endfunction

  // round half up, drop fraction, saturate
  function automatic logic signed [31:0] rnd(input logic signed [63:0] prod);
    logic signed [65:0] acc;
    acc = {{2{prod[63]}}, prod} + HALF66;
    return sat(acc >>> FRAC_BITS);
  endfunction

  // config registers
  logic [30:0] inv_cell_size;
  logic [30:0] time_step;
  logic [10:0] grid_cells;

  logic [NW-1:0]      n_eff;
  logic signed [31:0] dt_q;
  logic signed [31:0] hdt_q;

  // pipeline
  logic       vld [NST];
  item_t      pipe [NST];
  item_t      nxt [NST];

  // grid memories: e_y alone, e_x and b_z side by side
  logic signed [31:0] y_mem  [GRID_DEPTH];
  logic [63:0]        xb_mem [GRID_DEPTH];
  logic signed [31:0] y_lo_q;
  logic signed [31:0] y_hi_q;
  logic [63:0]        xb_lo_q;
  logic [63:0]        xb_hi_q;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_cell_size <= INV_CELL_RESET;
      time_step     <= TIME_STEP_RESET;
      grid_cells    <= GRID_CELLS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_INV_CELL:   inv_cell_size <= cfg_data[30:0];
        CFG_TIME_STEP:  time_step     <= cfg_data[30:0];
        CFG_GRID_CELLS: grid_cells    <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // grid size in use, clamped
  always_comb begin
    if (grid_cells < 11'd2) begin
      n_eff = NW'(2);
    end else if (32'(grid_cells) > GRID_DEPTH) begin
      n_eff = NW'(GRID_DEPTH);
    end else begin
      n_eff = NW'(grid_cells);
    end
  end

  assign dt_q  = sat({35'b0, time_step});
  assign hdt_q = sat({36'b0, time_step[30:1]});

  always_comb begin
    logic [IB-1:0]      i24;
    logic signed [31:0] iw;
    logic signed [31:0] nwide;
    logic [NW:0]        sh_m;
    logic [NW-1:0]      hi_n;
    logic signed [63:0] acc;
    logic [63:0]        bitv;
    logic [63:0]        trial;
    logic [44:0]        sh_d;
    logic [31:0]        absv;
    logic [31:0]        gamma;
    logic [52:0]        m_new;
    logic [63:0]        ttr;

    // accepted beat
    nxt[S_A]       = pipe[S_A];
    nxt[S_A].push  = (kind == KIND_PUSH);
    nxt[S_A].wen   = (kind == KIND_LOAD) && (32'(grid_index) < GRID_DEPTH);
    nxt[S_A].waddr = AW'(32'(grid_index));
    nxt[S_A].dx    = cell_e_x;
    nxt[S_A].dy    = cell_e_y;
    nxt[S_A].db    = cell_b_z;
    nxt[S_A].ux    = sat(x66(momentum_x));
    nxt[S_A].uy    = sat(x66(momentum_y));
    nxt[S_A].rqm   = sat(x66(charge_to_mass));
    nxt[S_A].pr0   = position * $signed({1'b0, inv_cell_size});

    for (int k = 1; k < NST; k++) begin
      nxt[k] = pipe[k - 1];
    end

    // cell index and fraction
    i24           = pipe[S_A].pr0[63:40];
    iw            = $signed({{(32 - IB){i24[IB-1]}}, i24});
    nwide         = $signed(32'(n_eff));
    nxt[S_B].frac = pipe[S_A].pr0[39:20];
    nxt[S_B].far  = (iw < -nwide) || (iw >= (nwide <<< 1));
    nxt[S_B].neg  = i24[IB-1];
    nxt[S_B].absi = i24[IB-1] ? (~i24 + IB'(1)) : i24;
    nxt[S_B].rem  = '0;

    // |index| mod n, restoring
    for (int k = 0; k < IB; k++) begin
      sh_m = {pipe[S_MOD0 + k - 1].rem, pipe[S_MOD0 + k - 1].absi[IB - 1 - k]};
      if (sh_m >= {1'b0, n_eff}) begin
        nxt[S_MOD0 + k].rem = NW'(sh_m - {1'b0, n_eff});
      end else begin
        nxt[S_MOD0 + k].rem = sh_m[NW-1:0];
      end
    end

    // negative index wraps from the top
    if (pipe[S_C1 - 1].neg && (pipe[S_C1 - 1].rem != '0)) begin
      nxt[S_C1].lo = n_eff - pipe[S_C1 - 1].rem;
    end else begin
      nxt[S_C1].lo = pipe[S_C1 - 1].rem;
    end

    // neighbour cells at integer and half-integer points
    hi_n = (pipe[S_C1].lo + NW'(1) == n_eff) ? '0 : pipe[S_C1].lo + NW'(1);
    nxt[S_C2].lo_a   = pipe[S_C1].lo[AW-1:0];
    nxt[S_C2].hi_a   = hi_n[AW-1:0];
    nxt[S_C2].frac_h = {~pipe[S_C1].frac[19], pipe[S_C1].frac[18:0]};
    if (!pipe[S_C1].frac[19]) begin
      if (pipe[S_C1].lo == '0) begin
        nxt[S_C2].lo_b = AW'(n_eff - NW'(1));
      end else begin
        nxt[S_C2].lo_b = AW'(pipe[S_C1].lo - NW'(1));
      end
      nxt[S_C2].hi_b = pipe[S_C1].lo[AW-1:0];
    end else begin
      nxt[S_C2].lo_b = pipe[S_C1].lo[AW-1:0];
      nxt[S_C2].hi_b = hi_n[AW-1:0];
    end

    // linear weights
    nxt[S_E].pr0 = $signed({1'b0, 21'(21'd1048576 - 21'(pipe[S_D].frac))}) * y_lo_q;
    nxt[S_E].pr1 = $signed({1'b0, pipe[S_D].frac}) * y_hi_q;
    nxt[S_E].pr2 = $signed({1'b0, 21'(21'd1048576 - 21'(pipe[S_D].frac_h))})
                   * $signed(xb_lo_q[63:32]);
    nxt[S_E].pr3 = $signed({1'b0, pipe[S_D].frac_h}) * $signed(xb_hi_q[63:32]);
    nxt[S_E].pr4 = $signed({1'b0, 21'(21'd1048576 - 21'(pipe[S_D].frac_h))})
                   * $signed(xb_lo_q[31:0]);
    nxt[S_E].pr5 = $signed({1'b0, pipe[S_D].frac_h}) * $signed(xb_hi_q[31:0]);

    acc          = (pipe[S_E].pr0 + pipe[S_E].pr1 + HALF64) >>> FRAC_BITS;
    nxt[S_F].ey  = acc[31:0];
    acc          = (pipe[S_E].pr2 + pipe[S_E].pr3 + HALF64) >>> FRAC_BITS;
    nxt[S_F].ex  = acc[31:0];
    acc          = (pipe[S_E].pr4 + pipe[S_E].pr5 + HALF64) >>> FRAC_BITS;
    nxt[S_F].bz  = acc[31:0];

    nxt[S_G].pr0 = pipe[S_F].rqm * pipe[S_F].ex;
    nxt[S_G].pr1 = pipe[S_F].rqm * pipe[S_F].ey;
    nxt[S_G].pr2 = pipe[S_F].rqm * pipe[S_F].bz;

    nxt[S_H].kx  = rnd(pipe[S_G].pr0);
    nxt[S_H].ky  = rnd(pipe[S_G].pr1);
    nxt[S_H].num = rnd(pipe[S_G].pr2);

    nxt[S_I].pr0 = pipe[S_H].kx * hdt_q;
    nxt[S_I].pr1 = pipe[S_H].ky * hdt_q;
    nxt[S_I].pr2 = pipe[S_H].num * dt_q;

    nxt[S_J].kx  = rnd(pipe[S_I].pr0);
    nxt[S_J].ky  = rnd(pipe[S_I].pr1);
    nxt[S_J].num = rnd(pipe[S_I].pr2);

    nxt[S_K].ux  = sat(x66(pipe[S_J].ux) + x66(pipe[S_J].kx));
    nxt[S_K].uy  = sat(x66(pipe[S_J].uy) + x66(pipe[S_J].ky));

    nxt[S_L].pr0 = pipe[S_K].ux * pipe[S_K].ux;
    nxt[S_L].pr1 = pipe[S_K].uy * pipe[S_K].uy;

    nxt[S_RAD].sv = 64'h0000_0100_0000_0000 + 64'(pipe[S_L].pr0) + 64'(pipe[S_L].pr1);
    nxt[S_RAD].sr = '0;

    // gamma, digit by digit
    for (int k = 0; k < 32; k++) begin
      bitv  = 64'd1 << (62 - 2 * k);
      trial = pipe[S_SQ0 + k - 1].sr + bitv;
      if (pipe[S_SQ0 + k - 1].sv >= trial) begin
        nxt[S_SQ0 + k].sv = pipe[S_SQ0 + k - 1].sv - trial;
        nxt[S_SQ0 + k].sr = (pipe[S_SQ0 + k - 1].sr >> 1) + bitv;
      end else begin
        nxt[S_SQ0 + k].sr = pipe[S_SQ0 + k - 1].sr >> 1;
      end
    end

    // t = rqm b dt / (2 gamma), rounded half away from zero
    gamma          = pipe[S_P - 1].sr[31:0];
    absv           = pipe[S_P - 1].num[31] ? 32'(-pipe[S_P - 1].num)
                                           : 32'(pipe[S_P - 1].num);
    m_new          = 53'({absv, 20'd0}) + 53'(gamma);
    nxt[S_P].neg   = pipe[S_P - 1].num[31];
    nxt[S_P].m     = m_new;
    nxt[S_P].den   = 43'({gamma, 1'b0});
    nxt[S_P].drem  = 44'(m_new >> QB_T);
    nxt[S_P].quo   = '0;

    for (int k = 0; k < QB_T; k++) begin
      sh_d = {pipe[S_DV1 + k - 1].drem, pipe[S_DV1 + k - 1].m[QB_T - 1 - k]};
      if (sh_d >= 45'(pipe[S_DV1 + k - 1].den)) begin
        nxt[S_DV1 + k].drem = 44'(sh_d - 45'(pipe[S_DV1 + k - 1].den));
        nxt[S_DV1 + k].quo  = {pipe[S_DV1 + k - 1].quo[29:0], 1'b1};
      end else begin
        nxt[S_DV1 + k].drem = sh_d[43:0];
        nxt[S_DV1 + k].quo  = {pipe[S_DV1 + k - 1].quo[29:0], 1'b0};
      end
    end

    if (pipe[S_T - 1].neg) begin
      nxt[S_T].t = sat(-$signed({35'b0, pipe[S_T - 1].quo}));
    end else begin
      nxt[S_T].t = sat($signed({35'b0, pipe[S_T - 1].quo}));
    end

    nxt[S_TT].pr0 = pipe[S_T].t * pipe[S_T].t;

    // s = 2t / (1 + t^2)
    ttr             = 64'(pipe[S_TT].pr0) + 64'd524288;
    nxt[S_D2A].den  = 43'((ttr >> FRAC_BITS) + 64'd1048576);
    absv            = pipe[S_TT].t[31] ? 32'(-pipe[S_TT].t) : 32'(pipe[S_TT].t);
    nxt[S_D2A].m    = {absv, 21'd0};
    nxt[S_D2A].neg  = pipe[S_TT].t[31];

    m_new           = pipe[S_D2A].m + 53'(pipe[S_D2A].den >> 1);
    nxt[S_D2B].m    = m_new;
    nxt[S_D2B].drem = 44'(m_new >> QB_S);
    nxt[S_D2B].quo  = '0;

    for (int k = 0; k < QB_S; k++) begin
      sh_d = {pipe[S_DV2 + k - 1].drem, pipe[S_DV2 + k - 1].m[QB_S - 1 - k]};
      if (sh_d >= 45'(pipe[S_DV2 + k - 1].den)) begin
        nxt[S_DV2 + k].drem = 44'(sh_d - 45'(pipe[S_DV2 + k - 1].den));
        nxt[S_DV2 + k].quo  = {pipe[S_DV2 + k - 1].quo[29:0], 1'b1};
      end else begin
        nxt[S_DV2 + k].drem = sh_d[43:0];
        nxt[S_DV2 + k].quo  = {pipe[S_DV2 + k - 1].quo[29:0], 1'b0};
      end
    end

    if (pipe[S_S - 1].neg) begin
      nxt[S_S].s = sat(-$signed({35'b0, pipe[S_S - 1].quo}));
    end else begin
      nxt[S_S].s = sat($signed({35'b0, pipe[S_S - 1].quo}));
    end

    // rotation as three shears
    nxt[S_R1].pr0     = pipe[S_S].uy * pipe[S_S].t;
    nxt[S_R1 + 1].rot = rnd(pipe[S_R1].pr0);
    nxt[S_R1 + 2].ux  = sat(x66(pipe[S_R1 + 1].ux) + x66(pipe[S_R1 + 1].rot));
    nxt[S_R1 + 3].pr0 = pipe[S_R1 + 2].ux * pipe[S_R1 + 2].s;
    nxt[S_R1 + 4].rot = rnd(pipe[S_R1 + 3].pr0);
    nxt[S_R1 + 5].uy  = sat(x66(pipe[S_R1 + 4].uy) - x66(pipe[S_R1 + 4].rot));
    nxt[S_R1 + 6].pr0 = pipe[S_R1 + 5].uy * pipe[S_R1 + 5].t;
    nxt[S_R1 + 7].rot = rnd(pipe[S_R1 + 6].pr0);
    nxt[S_R9].ux      = sat(x66(pipe[S_R1 + 7].ux) + x66(pipe[S_R1 + 7].rot));

    // second half kick
    nxt[S_OUT].ux = sat(x66(pipe[S_R9].ux) + x66(pipe[S_R9].kx));
    nxt[S_OUT].uy = sat(x66(pipe[S_R9].uy) + x66(pipe[S_R9].ky));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NST; k++) begin
        vld[k] <= 1'b0;
      end
    end else begin
      vld[S_A] <= start && !busy;
      for (int k = 1; k < NST; k++) begin
        vld[k] <= vld[k - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NST; k++) begin
      pipe[k] <= nxt[k];
    end
  end

  // grid access: loads write where pushes read, keeping item order
  always_ff @(posedge clk) begin
    if (vld[S_C2] && pipe[S_C2].wen) begin
      y_mem[pipe[S_C2].waddr]  <= pipe[S_C2].dy;
      xb_mem[pipe[S_C2].waddr] <= {pipe[S_C2].dx, pipe[S_C2].db};
    end
    y_lo_q  <= y_mem[pipe[S_C2].lo_a];
    y_hi_q  <= y_mem[pipe[S_C2].hi_a];
    xb_lo_q <= xb_mem[pipe[S_C2].lo_b];
    xb_hi_q <= xb_mem[pipe[S_C2].hi_b];
  end

  assign result_valid   = vld[S_OUT] && pipe[S_OUT].push;
  assign new_momentum_x = pipe[S_OUT].ux;
  assign new_momentum_y = pipe[S_OUT].uy;
  assign out_of_box     = pipe[S_OUT].far;

endmodule

// ----- tb/boris_particle_push_test.sv -----
// ----------------------------------------------------------------------------
// boris_particle_push_test
// self-checking bench for the relativistic boris pusher: loads field cells,
// pushes particles under several register settings and compares every result
// beat with a bit-exact q12.20 model of the push kept inside the bench
// ----------------------------------------------------------------------------
module boris_particle_push_test;
  import bpp_pkg::*;

  localparam int     DEPTH      = 1024;
  localparam longint ONE_Q      = 64'sd1048576;
  localparam longint HALF_Q     = 64'sd524288;
  localparam int     SETTLE     = 160;      // beyond the pipeline length
  localparam int     CYCLE_CAP  = 1000000;

  typedef struct packed {
    logic signed [31:0] mom_x;
    logic signed [31:0] mom_y;
    logic               far;
  } push_out_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               kind = 1'b0;
  logic [9:0]         grid_index = '0;
  logic signed [31:0] cell_e_x = '0;
  logic signed [31:0] cell_e_y = '0;
  logic signed [31:0] cell_b_z = '0;
  logic signed [31:0] position = '0;
  logic signed [31:0] momentum_x = '0;
  logic signed [31:0] momentum_y = '0;
  logic signed [31:0] charge_to_mass = '0;
  logic               result_valid;
  logic signed [31:0] new_momentum_x;
  logic signed [31:0] new_momentum_y;
  logic               out_of_box;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  boris_particle_push u_top (
    .clk, .rst, .start, .busy, .kind, .grid_index, .cell_e_x, .cell_e_y,
    .cell_b_z, .position, .momentum_x, .momentum_y, .charge_to_mass,
    .result_valid, .new_momentum_x, .new_momentum_y, .out_of_box,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #1 clk = ~clk;

  // bench copy of the block state
  logic signed [31:0] field_store [3][DEPTH];   // e_x, e_y, b_z
  bit                 cell_loaded [DEPTH];
  longint             inv_cell;
  longint             dt_reg;
  longint             cells_reg;

  push_out_t pending_pushes [$];
  int        fail_count = 0;
  int        cycle_count = 0;

  // ---------------------------------------------------------------- arithmetic
  function automatic longint sat32(input longint v);
    if (v >= 64'sd2147483648) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // product of two q12.20 values, rounded half up
  function automatic longint qmul(input longint a, input longint b);
    return sat32((a * b + HALF_Q) >>> 20);
  endfunction

  // rounds half away from zero
  function automatic longint div_away(input longint num, input bit [63:0] den);
    bit [63:0] mag;
    bit [63:0] quo;
    mag = (num < 0) ? 64'(-num) : 64'(num);
    quo = (mag + den / 2) / den;
    return (num < 0) ? -longint'(quo) : longint'(quo);
  endfunction

  function automatic bit [63:0] root64(input bit [63:0] v);
    bit [63:0] r;
    bit [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // linear mix of two neighbouring cells with periodic wrap
  function automatic longint cell_mix(input int sel, input longint q, input longint n);
    longint whole;
    longint frac;
    longint lo;
    longint hi;
    whole = q >>> 20;
    frac  = q & 64'hFFFFF;
    lo    = whole % n;
    if (lo < 0) lo = lo + n;
    hi = lo + 1;
    if (hi >= n) hi = 0;
    return ((ONE_Q - frac) * longint'(field_store[sel][lo])
            + frac * longint'(field_store[sel][hi]) + HALF_Q) >>> 20;
  endfunction

  function automatic longint live_cells();
    if (cells_reg < 2) return 2;
    if (cells_reg > DEPTH) return DEPTH;
    return cells_reg;
  endfunction

  function automatic push_out_t expected_push(input logic signed [31:0] pos,
                                              input logic signed [31:0] mx,
                                              input logic signed [31:0] my,
                                              input logic signed [31:0] rqm);
    longint    n, p, ex, ey, bz, ux, uy, hdt, kx, ky, num, t, s, tt;
    bit [63:0] gam, den;
    push_out_t res;
    n   = live_cells();
    p   = (longint'(pos) * inv_cell) >>> 20;
    res.far = (p < -n * ONE_Q) || (p >= 2 * n * ONE_Q);
    ex  = cell_mix(0, p - HALF_Q, n);
    ey  = cell_mix(1, p, n);
    bz  = cell_mix(2, p - HALF_Q, n);
    hdt = dt_reg >> 1;
    // first half electric kick
    kx  = qmul(qmul(rqm, ex), hdt);
    ky  = qmul(qmul(rqm, ey), hdt);
    ux  = sat32(mx + kx);
    uy  = sat32(my + ky);
    // magnetic rotation
    gam = root64((64'd1 << 40) + 64'(ux * ux) + 64'(uy * uy));
    num = qmul(qmul(rqm, bz), dt_reg);
    t   = sat32(div_away(num * ONE_Q, 2 * gam));
    tt  = t * t;
    den = 64'(ONE_Q) + ((64'(tt) + 64'(HALF_Q)) >> 20);
    s   = sat32(div_away(2 * t * ONE_Q, den));
    ux  = sat32(ux + qmul(uy, t));
    uy  = sat32(uy - qmul(ux, s));
    ux  = sat32(ux + qmul(uy, t));
    // second half kick
    res.mom_x = 32'(sat32(ux + kx));
    res.mom_y = 32'(sat32(uy + ky));
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus
  // mix of full range, small magnitudes, extremes and unit values
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2, 3: return 32'(signed'($urandom_range(0, 32'h3FFFFF)) - 32'sh200000);
      4:    return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      default: return $urandom_range(0, 1) ? 32'sh100000 : -32'sh100000;
    endcase
  endfunction

  task automatic idle_gap();
    int n;
    case ($urandom_range(0, 19))
      0:             n = $urandom_range(10, 40);
      1, 2, 3, 4, 5: n = $urandom_range(1, 3);
      default:       n = 0;
    endcase
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // one input beat; the model is updated at the edge that takes it
  task automatic send_beat(input kind_e k, input logic [9:0] idx,
                           input logic signed [31:0] ex, ey, bz,
                           input logic signed [31:0] pos, mx, my, rqm);
    start          <= 1'b1;
    kind           <= k;
    grid_index     <= idx;
    cell_e_x       <= ex;
    cell_e_y       <= ey;
    cell_b_z       <= bz;
    position       <= pos;
    momentum_x     <= mx;
    momentum_y     <= my;
    charge_to_mass <= rqm;
    do @(posedge clk); while (busy);
    if (k == KIND_LOAD) begin
      field_store[0][idx] = ex;
      field_store[1][idx] = ey;
      field_store[2][idx] = bz;
      cell_loaded[idx]    = 1'b1;
    end else begin
      pending_pushes.push_back(expected_push(pos, mx, my, rqm));
    end
    idle_gap();
  endtask

  task automatic load_cell(input logic [9:0] idx, input logic signed [31:0] ex, ey, bz);
    send_beat(KIND_LOAD, idx, ex, ey, bz, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic push_particle(input logic signed [31:0] pos, mx, my, rqm);
    send_beat(KIND_PUSH, 10'($urandom), $urandom, $urandom, $urandom, pos, mx, my, rqm);
  endtask

  // sender holds off until the pipeline has drained, loads included
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_pushes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // register beat; upper data bits are random as the block ignores them
  task automatic write_reg(input cfg_reg_e r, input longint value);
    logic [31:0] word;
    word = $urandom;
    case (r)
      CFG_INV_CELL:  word[30:0] = value[30:0];
      CFG_TIME_STEP: word[30:0] = value[30:0];
      default:       word[10:0] = value[10:0];
    endcase
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= word;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (r)
      CFG_INV_CELL:  inv_cell  = word[30:0];
      CFG_TIME_STEP: dt_reg    = word[30:0];
      default:       cells_reg = word[10:0];
    endcase
  endtask

  // every cell a push may read must hold a load first
  task automatic fill_cells();
    for (int c = 0; c < live_cells(); c++)
      if (!cell_loaded[c] || $urandom_range(0, 3) == 0)
        load_cell(10'(c), pick_value(), pick_value(), pick_value());
  endtask

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    push_out_t want;
    if (!rst && result_valid) begin
      if (pending_pushes.size() == 0) begin
        fail_count++;
        $display("%0t: result beat with none expected: x %h y %h far %b",
                 $time, new_momentum_x, new_momentum_y, out_of_box);
      end else begin
        want = pending_pushes.pop_front();
        if (new_momentum_x !== want.mom_x) begin
          fail_count++;
          $display("%0t: new_momentum_x expected %h actual %h",
                   $time, want.mom_x, new_momentum_x);
        end
        if (new_momentum_y !== want.mom_y) begin
          fail_count++;
          $display("%0t: new_momentum_y expected %h actual %h",
                   $time, want.mom_y, new_momentum_y);
        end
        if (out_of_box !== want.far) begin
          fail_count++;
          $display("%0t: out_of_box expected %b actual %b",
                   $time, want.far, out_of_box);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("boris_particle_push test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests
  // small grid, field and particle extremes, far positions on both sides
  task automatic test_extremes();
    write_reg(CFG_GRID_CELLS, 4);
    write_reg(CFG_INV_CELL, 1048576);
    write_reg(CFG_TIME_STEP, 524288);
    load_cell(0, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
    load_cell(1, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000);
    load_cell(2, 32'sh00100000, -32'sh00100000, 32'sh00080000);
    load_cell(3, 0, 0, 0);
    push_particle(0, 0, 0, 32'sh100000);
    push_particle(32'sh00180000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    push_particle(32'sh00280000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    push_particle(32'sh7FFFFFFF, 32'sh00100000, -32'sh00100000, -32'sh100000);
    push_particle(32'sh80000000, 0, 32'sh7FFFFFFF, 32'sh00200000);
    push_particle(32'sh007FFFFF, 32'sh00050000, 0, 32'sh7FFFFFFF); // last in-box cell
    push_particle(32'sh00800000, 32'sh00050000, 0, 32'sh7FFFFFFF); // first far cell
    push_particle(-32'sh00400000, 0, 0, 32'sh80000000);            // one box below
    push_particle(-32'sh00400001, 0, 0, 32'sh80000000);            // just beyond
  endtask

  // grid sizes below the minimum behave as two cells, and zero 1/dx
  task automatic test_grid_floor();
    write_reg(CFG_GRID_CELLS, 0);
    write_reg(CFG_TIME_STEP, 32'h7FFFFFFF);
    push_particle(32'sh00300000, 32'sh00100000, 0, 32'sh00100000);
    write_reg(CFG_GRID_CELLS, 1);
    push_particle(-32'sh00300000, 0, 32'sh00100000, -32'sh00100000);
    write_reg(CFG_INV_CELL, 0);
    push_particle(32'sh7FFFFFFF, 32'sh00200000, 32'sh00200000, 32'sh00300000);
    push_particle(32'sh80000000, 32'sh00200000, 32'sh00200000, 32'sh00300000);
  endtask

  // oversize grid setting clamps to the full depth; every cell loaded
  task automatic test_full_grid();
    write_reg(CFG_GRID_CELLS, 2047);
    write_reg(CFG_INV_CELL, 32'h7FFFFFFF);
    write_reg(CFG_TIME_STEP, $urandom_range(0, 32'h1FFFFF));
    fill_cells();
    repeat (60) push_particle(pick_value(), pick_value(), pick_value(), pick_value());
    write_reg(CFG_GRID_CELLS, 1024);
    write_reg(CFG_INV_CELL, $urandom_range(1, 32'h3FFFFF));
    repeat (40) push_particle(pick_value(), pick_value(), pick_value(), pick_value());
  endtask

  // random settings per phase, pushes mixed with fresh loads
  task automatic test_random_phases();
    int    budget;
    int    cells;
    longint inv_pick;
    budget = 250;
    while (budget > 0) begin
      case ($urandom_range(0, 9))
        0:       cells = $urandom_range(0, 2047);
        1:       cells = 2;
        default: cells = $urandom_range(2, 24);
      endcase
      write_reg(CFG_GRID_CELLS, cells);
      case ($urandom_range(0, 5))
        0:       inv_pick = $urandom_range(0, 1) ? 32'h7FFFFFFF : 0;
        1:       inv_pick = $urandom;
        default: inv_pick = $urandom_range(1, 32'h7FFFFF);
      endcase
      write_reg(CFG_INV_CELL, inv_pick);
      case ($urandom_range(0, 4))
        0:       write_reg(CFG_TIME_STEP, $urandom_range(0, 1) ? 32'h7FFFFFFF : 0);
        1:       write_reg(CFG_TIME_STEP, $urandom);
        default: write_reg(CFG_TIME_STEP, $urandom_range(0, 32'h1FFFFF));
      endcase
      fill_cells();
      repeat ($urandom_range(60, 140)) begin
        if ($urandom_range(0, 4) == 0)
          load_cell(10'($urandom_range(0, live_cells() - 1)), pick_value(), pick_value(),
                    pick_value());
        else
          push_particle(pick_value(), pick_value(), pick_value(), pick_value());
        budget--;
      end
    end
  endtask

  initial begin
    inv_cell  = INV_CELL_RESET;
    dt_reg    = TIME_STEP_RESET;
    cells_reg = GRID_CELLS_RESET;
    for (int c = 0; c < DEPTH; c++) cell_loaded[c] = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_grid_floor();
    test_full_grid();
    test_random_phases();
    drain();
    if (fail_count == 0) begin
      $display("boris_particle_push test passed");
    end else begin
      $display("boris_particle_push test failed");
    end
    $finish;
  end

endmodule
